>>> rtl/core/bvh_leaf_box_refit_core_defines.svh
// Assertion macros for the leaf box refit core
`ifndef BVH_LEAF_BOX_REFIT_CORE_DEFINES_SVH
`define BVH_LEAF_BOX_REFIT_CORE_DEFINES_SVH

// same-cycle implication
`define BVHLBR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bvhlbr: assertion failed");

// next-cycle implication
`define BVHLBR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bvhlbr: assertion failed");

`endif

>>> rtl/core/bvhlbr_pkg.sv
package bvhlbr_pkg;

  localparam int NodeCountDef = 1023;
  localparam int CoordBitsDef = 16;
  localparam int LeafIdxW     = 10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRI_RD,
    ST_CHECK,
    ST_LEAF,
    ST_CLIMB,
    ST_OUT
  } bvhlbr_state_e;

endpackage

>>> rtl/core/bvh_leaf_box_refit_core.sv
// Leaf box refit core for an implicit binary tree (node i has children 2i+1, 2i+2).
// Input channel: in_valid_i / in_stall_o carries one request: a node index and a
// triangle. Output channel: out_valid_o / out_stall_i carries the changed flag and
// the root box after the request.
// A request whose triangle matches the stored one, or whose index is out of
// range, returns changed = 0 and the current root box.
// An accepted request steps through ST_TRI_RD, ST_CHECK, ST_LEAF, one ST_CLIMB per
// tree level above the node, then ST_OUT, which loads the output; a matching
// triangle skips from ST_CHECK, an out-of-range index from ST_IDLE, to ST_OUT.
// One request is in flight at a time; in_stall_o is low again the cycle after
// the result is loaded. Each tree level costs one pass of the shared min/max
// unit and one box memory write, the sibling read ahead on the second memory port.
// After reset a clearing pass empties every box and invalidates every stored
// triangle; in_stall_o stays high meanwhile.
// A stalled result holds in the output register; the next request is accepted
// meanwhile but its result waits until the register is free.
module bvh_leaf_box_refit_core #(
  parameter int NODE_COUNT = bvhlbr_pkg::NodeCountDef,
  parameter int COORD_BITS = bvhlbr_pkg::CoordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bvhlbr_pkg::LeafIdxW-1:0]     leaf_index_i,
  input  logic signed [COORD_BITS-1:0]        v1_x_i,
  input  logic signed [COORD_BITS-1:0]        v1_y_i,
  input  logic signed [COORD_BITS-1:0]        v1_z_i,
  input  logic signed [COORD_BITS-1:0]        v2_x_i,
  input  logic signed [COORD_BITS-1:0]        v2_y_i,
  input  logic signed [COORD_BITS-1:0]        v2_z_i,
  input  logic signed [COORD_BITS-1:0]        v3_x_i,
  input  logic signed [COORD_BITS-1:0]        v3_y_i,
  input  logic signed [COORD_BITS-1:0]        v3_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                changed_o,
  output logic signed [COORD_BITS-1:0]        root_min_x_o,
  output logic signed [COORD_BITS-1:0]        root_min_y_o,
  output logic signed [COORD_BITS-1:0]        root_min_z_o,
  output logic signed [COORD_BITS-1:0]        root_max_x_o,
  output logic signed [COORD_BITS-1:0]        root_max_y_o,
  output logic signed [COORD_BITS-1:0]        root_max_z_o
);
  import bvhlbr_pkg::*;

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int EXT_W = ((IDX_W > LeafIdxW) ? IDX_W : LeafIdxW) + 1;
  localparam int TRI_W = 9 * COORD_BITS + 1;

  typedef logic [2:0][COORD_BITS-1:0] axes_t;
  typedef logic [1:0][2:0][COORD_BITS-1:0] box_t;

  localparam logic [COORD_BITS-1:0] CoordMax = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] CoordMin = {1'b1, {(COORD_BITS-1){1'b0}}};

  bvhlbr_state_e state_q, state_d;

  logic [IDX_W-1:0]              clr_q;
  logic [IDX_W-1:0]              node_q;
  logic [IDX_W-1:0]              down_q;
  logic [8:0][COORD_BITS-1:0]    vert_q;
  logic                          changed_q;
  axes_t                         acc_lo_q, acc_hi_q;
  axes_t                         root_lo_q, root_hi_q;
  logic                          sib_ok_q;
  logic                          out_valid_q;
  logic                          out_changed_q;
  axes_t                         out_lo_q, out_hi_q;

  box_t                          box_mem [NODE_COUNT];
  box_t                          box_rd_q;
  logic [TRI_W-1:0]              tri_mem [NODE_COUNT];
  logic [TRI_W-1:0]              tri_rd_q;

  logic                          in_range;
  logic                          same;
  logic                          out_free;
  logic [IDX_W-1:0]              parent;
  logic [IDX_W-1:0]              nxt_down;
  logic [IDX_W:0]                sib_w;
  logic                          sib_ok;
  logic [IDX_W-1:0]              box_rd_addr;
  axes_t                         v1, v2, v3;
  axes_t                         ua_lo, ua_hi, ub_lo, ub_hi, u_lo, u_hi;
  logic                          box_we;
  logic [IDX_W-1:0]              box_wr_addr;
  box_t                          box_wr_data;
  logic                          tri_we;
  logic [IDX_W-1:0]              tri_wr_addr;
  logic [TRI_W-1:0]              tri_wr_data;

  assign in_range = EXT_W'(leaf_index_i) < EXT_W'(NODE_COUNT);
  assign same     = tri_rd_q[TRI_W-1] && (tri_rd_q[TRI_W-2:0] == vert_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign parent   = (down_q - IDX_W'(1)) >> 1;
  assign nxt_down = (state_q == ST_LEAF) ? node_q : parent;
  assign sib_w    = nxt_down[0] ? ({1'b0, nxt_down} + (IDX_W+1)'(1))
                                : ({1'b0, nxt_down} - (IDX_W+1)'(1));
  assign sib_ok      = sib_w < (IDX_W+1)'(NODE_COUNT);
  assign box_rd_addr = sib_ok ? sib_w[IDX_W-1:0] : '0;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      v1[a] = vert_q[a];
      v2[a] = vert_q[3 + a];
      v3[a] = vert_q[6 + a];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == IDX_W'(NODE_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = in_range ? ST_TRI_RD : ST_OUT;
      ST_TRI_RD: state_d = ST_CHECK;
      ST_CHECK:  state_d = same ? ST_OUT : ST_LEAF;
      ST_LEAF:   state_d = (node_q == '0) ? ST_OUT : ST_CLIMB;
      ST_CLIMB:  if (parent == '0) state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath control and shared min/max unit operands
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    ua_lo       = acc_lo_q;
    ua_hi       = acc_hi_q;
    ub_lo       = acc_lo_q;
    ub_hi       = acc_hi_q;
    box_we      = 1'b0;
    box_wr_addr = node_q;
    tri_we      = 1'b0;
    tri_wr_addr = node_q;
    tri_wr_data = {1'b1, vert_q};
    unique case (state_q)
      ST_CLEAR: begin
        box_we      = 1'b1;
        box_wr_addr = clr_q;
        tri_we      = 1'b1;
        tri_wr_addr = clr_q;
        tri_wr_data = '0;
      end
      ST_CHECK: begin
        ua_lo  = v1;
        ua_hi  = v1;
        ub_lo  = v2;
        ub_hi  = v2;
        tri_we = !same;
      end
      ST_LEAF: begin
        ub_lo  = v3;
        ub_hi  = v3;
        box_we = 1'b1;
      end
      ST_CLIMB: begin
        if (sib_ok_q) begin
          ub_lo = box_rd_q[0];
          ub_hi = box_rd_q[1];
        end
        box_we      = 1'b1;
        box_wr_addr = parent;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      u_lo[a] = ($signed(ub_lo[a]) < $signed(ua_lo[a])) ? ub_lo[a] : ua_lo[a];
      u_hi[a] = ($signed(ub_hi[a]) > $signed(ua_hi[a])) ? ub_hi[a] : ua_hi[a];
    end
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      box_wr_data[0] = {3{CoordMax}};
      box_wr_data[1] = {3{CoordMin}};
    end else begin
      box_wr_data[0] = u_lo;
      box_wr_data[1] = u_hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_we) box_mem[box_wr_addr] <= box_wr_data;
    box_rd_q <= box_mem[box_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tri_we) tri_mem[tri_wr_addr] <= tri_wr_data;
    tri_rd_q <= tri_mem[node_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      root_lo_q   <= {3{CoordMax}};
      root_hi_q   <= {3{CoordMin}};
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + IDX_W'(1);
      if (box_we && (box_wr_addr == '0)) begin
        root_lo_q <= box_wr_data[0];
        root_hi_q <= box_wr_data[1];
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sib_ok_q <= sib_ok;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          node_q    <= IDX_W'(leaf_index_i);
          vert_q    <= {v3_z_i, v3_y_i, v3_x_i, v2_z_i, v2_y_i, v2_x_i,
                        v1_z_i, v1_y_i, v1_x_i};
          changed_q <= 1'b0;
        end
      end
      ST_CHECK: begin
        acc_lo_q  <= u_lo;
        acc_hi_q  <= u_hi;
        changed_q <= !same;
      end
      ST_LEAF: begin
        acc_lo_q <= u_lo;
        acc_hi_q <= u_hi;
        down_q   <= node_q;
      end
      ST_CLIMB: begin
        acc_lo_q <= u_lo;
        acc_hi_q <= u_hi;
        down_q   <= parent;
      end
      ST_OUT: begin
        if (out_free) begin
          out_changed_q <= changed_q;
          out_lo_q      <= root_lo_q;
          out_hi_q      <= root_hi_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign changed_o    = out_changed_q;
  assign root_min_x_o = out_lo_q[0];
  assign root_min_y_o = out_lo_q[1];
  assign root_min_z_o = out_lo_q[2];
  assign root_max_x_o = out_hi_q[0];
  assign root_max_y_o = out_hi_q[1];
  assign root_max_z_o = out_hi_q[2];

endmodule

>>> rtl/core/bvhlbr_checker.sv
`include "bvh_leaf_box_refit_core_defines.svh"

module bvhlbr_checker #(
  parameter int COORD_BITS = bvhlbr_pkg::CoordBitsDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         changed_o,
  input logic signed [COORD_BITS-1:0] root_min_x_o,
  input logic signed [COORD_BITS-1:0] root_min_y_o,
  input logic signed [COORD_BITS-1:0] root_min_z_o,
  input logic signed [COORD_BITS-1:0] root_max_x_o,
  input logic signed [COORD_BITS-1:0] root_max_y_o,
  input logic signed [COORD_BITS-1:0] root_max_z_o
);

  logic root_ordered;

  assign root_ordered = (root_min_x_o <= root_max_x_o) && (root_min_y_o <= root_max_y_o) &&
                        (root_min_z_o <= root_max_z_o);

  // one request at a time
  `BVHLBR_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `BVHLBR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `BVHLBR_ASSERT_NXT(a_no_out_in_reset, clk_i, 1'b1, !rst_ni, !out_valid_o)

  // a refit root box is never empty
  `BVHLBR_ASSERT_IMP(a_root_ordered, clk_i, rst_ni, out_valid_o && changed_o, root_ordered)

endmodule

bind bvh_leaf_box_refit_core bvhlbr_checker #(.COORD_BITS(COORD_BITS)) u_bvhlbr_checker (.*);
